>>> design/gmt_pkg.sv
// ----------------------------------------------------------------------------
// gmt_pkg: shared types and constants of the gossip membership table
// Opcodes, register indexes, table entry layout and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package gmt_pkg;

   // request opcodes
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_JOIN  = 2'd1;
   localparam logic [1:0] OP_MERGE = 2'd2;
   localparam logic [1:0] OP_TICK  = 2'd3;

   // result kinds
   localparam logic KIND_REPLY  = 1'b0;
   localparam logic KIND_GOSSIP = 1'b1;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SELF_ID      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SELF_PORT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FAIL_TIMEOUT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REMOVE_TMO   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_HB      = 3'd4;

   // configuration reset values
   localparam logic [15:0] FAIL_TIMEOUT_RST   = 16'd5;
   localparam logic [15:0] REMOVE_TIMEOUT_RST = 16'd20;

   // join address: being this node means joining at once
   localparam logic [31:0] JOIN_ID   = 32'd1;
   localparam logic [15:0] JOIN_PORT = 16'd0;

   // at most this many result words per request
   localparam int MAX_OUT   = 16;
   localparam int OUT_CNT_W = $clog2(MAX_OUT + 1);

   typedef struct packed {
      logic [31:0] id;
      logic [15:0] port;
      logic [31:0] heartbeat;
      logic [31:0] stamp;
   } entry_type;

   typedef struct packed {
      logic [31:0] self_id;
      logic [15:0] self_port;
      logic [15:0] fail_timeout;
      logic [15:0] remove_timeout;
      logic [31:0] initial_heartbeat;
   } cfg_type;

   // controller -> datapath
   typedef struct packed {
      logic exec;       // opcode head action (start/append/group flag)
      logic scan_init;  // rewind scan pointers
      logic scan;       // walk the table
      logic tail;       // merge append or tick fill commit
      logic flush;      // release the held word as the last one
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_done;
      logic pend_busy;
      logic in_group;
   } dp_status_type;

endpackage

>>> design/gossip_membership_table_core.sv
// ----------------------------------------------------------------------------
// gossip_membership_table_core: gossip heartbeat membership table
// Start and an out-of-group tick do not scan the table; join, merge and tick
// read the n used entries one per cycle while the result output does not
// stall the scan. One request is taken at a time; the next waits until the
// current one is finished.
// Reset (synchronous): table empty, out of group, registers at reset values;
// entry contents are not cleared, an empty fill count hides them.
// ----------------------------------------------------------------------------
module gossip_membership_table_core
   import gmt_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   // request stream
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // [31:0] member_id, [47:32] member_port, [79:48] member_heartbeat,
   // [111:80] current_time
   input  logic [111:0]         req_tdata,
   // [1:0] opcode, [2] from_reply
   input  logic [2:0]           req_tuser,
   // result stream
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // [31:0] out_id, [47:32] out_port, [79:48] out_heartbeat
   output logic [79:0]          rsp_tdata,
   // [0] kind
   output logic [0:0]           rsp_tuser,
   output logic                 rsp_tlast,
   // register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   cfg_type       cfg_ff;
   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_accept;
   logic          rsp_kind;
   logic [31:0]   rsp_id, rsp_hb;
   logic [15:0]   rsp_port;

   assign csr_ready  = 1'b1;
   assign req_accept = req_tvalid && req_tready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.self_id           <= '0;
         cfg_ff.self_port         <= '0;
         cfg_ff.fail_timeout      <= FAIL_TIMEOUT_RST;
         cfg_ff.remove_timeout    <= REMOVE_TIMEOUT_RST;
         cfg_ff.initial_heartbeat <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SELF_ID:      cfg_ff.self_id           <= csr_data;
            CSR_SELF_PORT:    cfg_ff.self_port         <= csr_data[15:0];
            CSR_FAIL_TIMEOUT: cfg_ff.fail_timeout      <= csr_data[15:0];
            CSR_REMOVE_TMO:   cfg_ff.remove_timeout    <= csr_data[15:0];
            CSR_INIT_HB:      cfg_ff.initial_heartbeat <= csr_data;
            default: begin
            end
         endcase
      end
   end

   gmt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_opcode (req_tuser[1:0]),
      .req_ready  (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   gmt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_accept           (req_accept),
      .req_opcode           (req_tuser[1:0]),
      .req_from_reply       (req_tuser[2]),
      .req_member_id        (req_tdata[31:0]),
      .req_member_port      (req_tdata[47:32]),
      .req_member_heartbeat (req_tdata[79:48]),
      .req_current_time     (req_tdata[111:80]),
      .cfg                  (cfg_ff),
      .cmd                  (cmd),
      .status               (status),
      .rsp_valid            (rsp_tvalid),
      .rsp_ready            (rsp_tready),
      .rsp_kind             (rsp_kind),
      .rsp_id               (rsp_id),
      .rsp_port             (rsp_port),
      .rsp_heartbeat        (rsp_hb),
      .rsp_last             (rsp_tlast)
   );

   assign rsp_tdata = {rsp_hb, rsp_port, rsp_id};
   assign rsp_tuser = rsp_kind;

endmodule

>>> design/gmt_ctrl.sv
// ----------------------------------------------------------------------------
// gmt_ctrl: request sequencer of the gossip membership table
// Takes one request at a time and steps the datapath through head action,
// table scan, tail action and output flush (start and an out-of-group tick stop after the head action).
// ----------------------------------------------------------------------------
module gmt_ctrl
   import gmt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_opcode,
   output logic          req_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXEC  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_TAIL  = 3'd3;
   localparam logic [2:0] ST_FLUSH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [1:0] op_ff;

   assign req_ready = (state_ff == ST_IDLE);

   // opcode of the request in work
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) op_ff <= req_opcode;
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (op_ff == OP_START) begin
               state_in = ST_IDLE;
            end else if (op_ff == OP_TICK && !status.in_group) begin
               state_in = ST_IDLE;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) state_in = ST_TAIL;
         end
         ST_TAIL: begin
            cmd.tail = 1'b1;
            state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            cmd.flush = 1'b1;
            if (!status.pend_busy) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/gmt_datapath.sv
// ----------------------------------------------------------------------------
// gmt_datapath: table memory, scan pipeline and output staging
// One table read per cycle unless the output stalls; the evaluated entry is
// matched, aged, rewritten (compacted on tick) and possibly listed. One listed
// word is held back so that the final word of a message can carry last.
// ----------------------------------------------------------------------------
module gmt_datapath
   import gmt_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_accept,
   input  logic [1:0]    req_opcode,
   input  logic          req_from_reply,
   input  logic [31:0]   req_member_id,
   input  logic [15:0]   req_member_port,
   input  logic [31:0]   req_member_heartbeat,
   input  logic [31:0]   req_current_time,
   input  cfg_type       cfg,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_kind,
   output logic [31:0]   rsp_id,
   output logic [15:0]   rsp_port,
   output logic [31:0]   rsp_heartbeat,
   output logic          rsp_last
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   // latched request
   logic [1:0]  op_ff;
   logic        reply_ff;
   logic [31:0] mid_ff;
   logic [15:0] mport_ff;
   logic [31:0] mhb_ff;
   logic [31:0] now_ff;

   // table memory
   entry_type entry_mem_ff [TABLE_DEPTH];
   entry_type rd_data_ff;
   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   entry_type     mem_wdata;

   // table state
   logic [CW-1:0] fill_ff, fill_in;
   logic          in_group_ff, in_group_in;
   logic          full;

   // scan pipeline
   logic [CW-1:0]        rd_ptr_ff;
   logic [CW-1:0]        wr_ptr_ff;
   logic [IW-1:0]        ev_idx_ff;
   logic                 ev_valid_ff;
   logic                 found_ff;
   logic [OUT_CNT_W-1:0] emit_cnt_ff;
   logic                 adv, stall, rd_issue;

   // evaluation of the entry in the read register
   logic        is_match, is_self, too_old, fresh;
   logic [31:0] age;
   logic        want_emit, emit_req, ev_we, ev_keep;
   logic [IW-1:0] ev_waddr;
   entry_type   ev_wdata, emit_entry;

   // output staging
   logic        pend_v_ff, pend_v_in;
   logic        pend_kind_ff;
   logic [31:0] pend_id_ff, pend_hb_ff;
   logic [15:0] pend_port_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff, rsp_last_ff, out_last_in;
   logic [31:0] rsp_id_ff, rsp_hb_ff;
   logic [15:0] rsp_port_ff;
   logic        load_out, load_pend, out_free;

   // request capture
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff    <= req_opcode;
         reply_ff <= req_from_reply;
         mid_ff   <= req_member_id;
         mport_ff <= req_member_port;
         mhb_ff   <= req_member_heartbeat;
         now_ff   <= req_current_time;
      end
   end

   assign full = (fill_ff == CW'(TABLE_DEPTH));

   // entry evaluation
   always_comb begin
      is_match  = (rd_data_ff.id == mid_ff) && (rd_data_ff.port == mport_ff);
      is_self   = (rd_data_ff.id == cfg.self_id) && (rd_data_ff.port == cfg.self_port);
      age       = now_ff - rd_data_ff.stamp;
      too_old   = age > {16'd0, cfg.remove_timeout};
      fresh     = age <= {16'd0, cfg.fail_timeout};
      want_emit = 1'b0;
      ev_we     = 1'b0;
      ev_keep   = 1'b0;
      ev_waddr  = ev_idx_ff;
      ev_wdata  = rd_data_ff;
      unique case (op_ff)
         OP_JOIN: begin
            want_emit = 1'b1;
         end
         OP_MERGE: begin
            ev_we              = is_match && (rd_data_ff.heartbeat < mhb_ff);
            ev_wdata.heartbeat = mhb_ff;
            ev_wdata.stamp     = now_ff;
         end
         OP_TICK: begin
            ev_waddr = wr_ptr_ff[IW-1:0];
            if (is_self) begin
               ev_wdata.heartbeat = rd_data_ff.heartbeat + 32'd1;
               ev_wdata.stamp     = now_ff;
               ev_we              = 1'b1;
               ev_keep            = 1'b1;
               want_emit          = 1'b1;
            end else if (!too_old) begin
               ev_we     = 1'b1;
               ev_keep   = 1'b1;
               want_emit = fresh;
            end
         end
         default: begin
         end
      endcase
      emit_entry = (op_ff == OP_TICK) ? ev_wdata : rd_data_ff;
   end

   // scan flow control: a second listed word waits for the output register
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit_req = ev_valid_ff && want_emit && (emit_cnt_ff < OUT_CNT_W'(MAX_OUT));
   assign stall    = emit_req && pend_v_ff && !out_free;
   assign adv      = cmd.scan && !stall;
   assign rd_issue = adv && (rd_ptr_ff < fill_ff);

   // memory write port select
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = fill_ff[IW-1:0];
      mem_wdata.id        = mid_ff;
      mem_wdata.port      = mport_ff;
      mem_wdata.heartbeat = mhb_ff;
      mem_wdata.stamp     = now_ff;
      priority if (cmd.exec && op_ff == OP_START) begin
         mem_we              = 1'b1;
         mem_waddr           = '0;
         mem_wdata.id        = cfg.self_id;
         mem_wdata.port      = cfg.self_port;
         mem_wdata.heartbeat = cfg.initial_heartbeat;
      end else if (cmd.exec && op_ff == OP_JOIN && !full) begin
         mem_we = 1'b1;
      end else if (cmd.tail && op_ff == OP_MERGE && !found_ff && !full) begin
         mem_we = 1'b1;
      end else if (ev_valid_ff && adv && ev_we) begin
         mem_we    = 1'b1;
         mem_waddr = ev_waddr;
         mem_wdata = ev_wdata;
      end else begin
         mem_we = 1'b0;
      end
   end

   // table memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) entry_mem_ff[mem_waddr] <= mem_wdata;
      if (rd_issue) rd_data_ff <= entry_mem_ff[rd_ptr_ff[IW-1:0]];
   end

   // fill count and group flag
   always_comb begin
      fill_in     = fill_ff;
      in_group_in = in_group_ff;
      if (cmd.exec && op_ff == OP_START) begin
         fill_in     = CW'(1);
         in_group_in = (cfg.self_id == JOIN_ID) && (cfg.self_port == JOIN_PORT);
      end
      if (cmd.exec && op_ff == OP_JOIN && !full) fill_in = fill_ff + CW'(1);
      if (cmd.exec && op_ff == OP_MERGE && reply_ff) in_group_in = 1'b1;
      if (cmd.tail && op_ff == OP_MERGE && !found_ff && !full) fill_in = fill_ff + CW'(1);
      if (cmd.tail && op_ff == OP_TICK) fill_in = wr_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         in_group_ff <= 1'b0;
      end else begin
         fill_ff     <= fill_in;
         in_group_ff <= in_group_in;
      end
   end

   // scan pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff   <= '0;
         wr_ptr_ff   <= '0;
         ev_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
         emit_cnt_ff <= '0;
      end else if (cmd.scan_init) begin
         rd_ptr_ff   <= '0;
         wr_ptr_ff   <= '0;
         ev_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
         emit_cnt_ff <= '0;
      end else if (adv) begin
         ev_valid_ff <= rd_issue;
         if (rd_issue) rd_ptr_ff <= rd_ptr_ff + CW'(1);
         if (ev_valid_ff) begin
            if (ev_keep) wr_ptr_ff <= wr_ptr_ff + CW'(1);
            if (is_match) found_ff <= 1'b1;
            if (emit_req) emit_cnt_ff <= emit_cnt_ff + OUT_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_issue) ev_idx_ff <= rd_ptr_ff[IW-1:0];
   end

   // output staging: held word leaves when the next arrives or at flush
   always_comb begin
      pend_v_in    = pend_v_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      load_out     = 1'b0;
      load_pend    = 1'b0;
      out_last_in  = 1'b0;
      if (emit_req && adv) begin
         load_pend = 1'b1;
         pend_v_in = 1'b1;
         if (pend_v_ff) begin
            load_out     = 1'b1;
            rsp_valid_in = 1'b1;
         end
      end else if (cmd.flush && pend_v_ff && out_free) begin
         load_out     = 1'b1;
         out_last_in  = 1'b1;
         rsp_valid_in = 1'b1;
         pend_v_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_kind_ff <= pend_kind_ff;
         rsp_id_ff   <= pend_id_ff;
         rsp_port_ff <= pend_port_ff;
         rsp_hb_ff   <= pend_hb_ff;
         rsp_last_ff <= out_last_in;
      end
      if (load_pend) begin
         pend_kind_ff <= (op_ff == OP_TICK) ? KIND_GOSSIP : KIND_REPLY;
         pend_id_ff   <= emit_entry.id;
         pend_port_ff <= emit_entry.port;
         pend_hb_ff   <= emit_entry.heartbeat;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_id        = rsp_id_ff;
   assign rsp_port      = rsp_port_ff;
   assign rsp_heartbeat = rsp_hb_ff;
   assign rsp_last      = rsp_last_ff;

   assign status.scan_done = !ev_valid_ff && (rd_ptr_ff == fill_ff);
   assign status.pend_busy = pend_v_ff;
   assign status.in_group  = in_group_ff;

endmodule

>>> design/gmt_checker.sv
// ----------------------------------------------------------------------------
// gmt_checker: port-level checks of the gossip membership table
// Watches the request and result streams of the top level over time.
// ----------------------------------------------------------------------------
module gmt_checker
   import gmt_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [2:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic        rsp_tlast
);

   // nothing pending right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word valid after reset");

   // one request at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while previous in work");

   // a start request lists nothing
   a_start_silent: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser[1:0] == OP_START && !rsp_tvalid)
      |=> !rsp_tvalid)
      else $error("result word after start request");

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready)
      |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result word changed");

endmodule

bind gossip_membership_table_core gmt_checker u_gmt_checker (.*);
